// ===== rtl/prs80_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prs80_pkg: shared types and round functions
// S-box, bit permutation and key schedule step of the 80-bit-key block
// cipher, plus the word type that moves from cell to cell.
// ----------------------------------------------------------------------------
package prs80_pkg;

    localparam int BLOCK_W       = 64;
    localparam int KEY_W         = 80;
    localparam int KEY_HIGH_W    = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 1;
    localparam int RND_W         = 5;
    localparam int ROUND_COUNT_DEF = 31;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

    // one word in flight: cipher state and the running key register
    typedef struct packed {
        logic [BLOCK_W-1:0] state;
        logic [KEY_W-1:0]   key;
    } stage_t;

    function automatic logic [3:0] sbox4(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hc;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hb;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'ha;
            4'h7: y = 4'hd;
            4'h8: y = 4'h3;
            4'h9: y = 4'he;
            4'ha: y = 4'hf;
            4'hb: y = 4'h8;
            4'hc: y = 4'h4;
            4'hd: y = 4'h7;
            4'he: y = 4'h1;
            default: y = 4'h2;
        endcase
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = sbox4(s[4*n +: 4]);
        end
        return r;
    endfunction

    // bit i moves to 16*i mod 63; the top bit stays
    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < BLOCK_W; i++) begin
            if (i == BLOCK_W - 1) begin
                r[BLOCK_W-1] = s[i];
            end else begin
                r[(16 * i) % (BLOCK_W - 1)] = s[i];
            end
        end
        return r;
    endfunction

    // rotate left by 61, S-box on the top nibble, round number into bits 19..15
    function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] k,
                                                  input logic [RND_W-1:0] rnd);
        logic [KEY_W-1:0] r;
        r = {k[18:0], k[KEY_W-1:19]};
        r[KEY_W-1 -: 4] = sbox4(r[KEY_W-1 -: 4]);
        r[19:15] = r[19:15] ^ rnd;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/prs80_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prs80_cell: one cipher round
// Holds one word (state and key) and hands it to the next cell when that
// cell can take it.
// ----------------------------------------------------------------------------
module prs80_cell #(
    parameter int ROUND_NUM = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire prs80_pkg::stage_t up_word,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output prs80_pkg::stage_t     dn_word
);
    import prs80_pkg::*;

    localparam logic [RND_W-1:0] RND = RND_W'(ROUND_NUM);

    logic   valid_reg;
    stage_t word_reg;
    stage_t word_next;

    // take a word when empty or when the held word leaves this cycle
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        word_next.state = perm_layer(sub_layer(up_word.state ^ up_word.key[KEY_W-1 -: BLOCK_W]));
        word_next.key   = key_step(up_word.key, RND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready) begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule
`default_nettype wire

// ===== rtl/lightweight_block_encrypt_80_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while ciphertext_ready is high; each round is its own cell
// in a chain of ROUND_COUNT.
// Ready ripples back through the chain, so an empty cell takes a word while later ones stall.
// Reset clears every cell's valid flag and both key registers (key reads as zero).
// ----------------------------------------------------------------------------
// lightweight_block_encrypt_80_unit: 64-bit block encryption, 80-bit key
// Chain of round cells, each carrying the block state together with its
// own copy of the key register, so the schedule runs alongside the data.
// ----------------------------------------------------------------------------
module lightweight_block_encrypt_80_unit #(
    parameter int ROUND_COUNT = prs80_pkg::ROUND_COUNT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [prs80_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [prs80_pkg::CFG_DATA_W-1:0]    cfg_data,
    // plaintext channel
    input  wire logic                                plaintext_valid,
    output logic                                     plaintext_ready,
    input  wire logic [prs80_pkg::BLOCK_W-1:0]       plaintext,
    // ciphertext channel
    output logic                                     ciphertext_valid,
    input  wire logic                                ciphertext_ready,
    output logic [prs80_pkg::BLOCK_W-1:0]            ciphertext
);
    import prs80_pkg::*;

    // master key registers
    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [KEY_HIGH_W-1:0] key_high_reg;

    // chain links: index 0 is the input side, index ROUND_COUNT the last cell
    logic   link_valid [ROUND_COUNT+1];
    logic   link_ready [1:ROUND_COUNT+1];
    stage_t link_word  [ROUND_COUNT+1];

    // ------------------------------------------------------------------
    // Configuration decode: write the addressed key register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data[KEY_HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Feed the chain: the plaintext enters with the full master key
    // ------------------------------------------------------------------
    assign link_valid[0]      = plaintext_valid;
    assign link_word[0].state = plaintext;
    assign link_word[0].key   = {key_high_reg, key_low_reg};
    assign plaintext_ready    = link_ready[1];

    // ------------------------------------------------------------------
    // Round cells: cell r runs round r and updates the key with counter r
    // ------------------------------------------------------------------
    for (genvar r = 1; r <= ROUND_COUNT; r++) begin : g_round
        prs80_cell #(
            .ROUND_NUM (r)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[r-1]),
            .up_ready (link_ready[r]),
            .up_word  (link_word[r-1]),
            .dn_valid (link_valid[r]),
            .dn_ready (link_ready[r+1]),
            .dn_word  (link_word[r])
        );
    end

    // ------------------------------------------------------------------
    // Output: the last cell's register is the output register; apply the
    // final key addition on its way out
    // ------------------------------------------------------------------
    assign link_ready[ROUND_COUNT+1] = ciphertext_ready;
    assign ciphertext_valid = link_valid[ROUND_COUNT];
    assign ciphertext = link_word[ROUND_COUNT].state ^
                        link_word[ROUND_COUNT].key[KEY_W-1 -: BLOCK_W];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an open output means every cell can move, so the input is open too
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        ciphertext_ready |-> plaintext_ready)
        else $error("ready did not propagate through the round chain");

    // a word handed to a cell is held there in the next cycle
    for (genvar k = 1; k <= ROUND_COUNT; k++) begin : g_chk
        a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
            link_valid[k-1] && link_ready[k] |=> link_valid[k])
            else $error("word lost between round cells");
    end

    // an accepted word leaves the input side only while the first cell is free
    a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (plaintext_valid && plaintext_ready) |-> (!link_valid[1] || link_ready[2]))
        else $error("first round cell overwritten while occupied");

endmodule
`default_nettype wire

// ===== tb/sv/lightweight_block_encrypt_80_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lightweight_block_encrypt_80_unit_tb: self-checking bench for the cipher
// Encrypts plaintext words through the round chain under a series of keys.
// A local bit-level model of the cipher predicts each ciphertext word, and
// every word that leaves the block is compared in order against it.
// ----------------------------------------------------------------------------
module lightweight_block_encrypt_80_unit_tb;

    localparam int ROUNDS        = prs80_pkg::ROUND_COUNT_DEF;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_BLOCKS = 700;
    localparam int PHASE_BLOCKS  = 50;
    localparam int SETTLE_CYCLES = ROUNDS + 8;
    localparam int IDLE_PERCENT  = 6;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        cfg_we           = 1'b0;
    logic [prs80_pkg::CFG_INDEX_W-1:0] cfg_index = prs80_pkg::REG_KEY_LOW;
    logic [prs80_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic        plaintext_valid  = 1'b0;
    logic        plaintext_ready;
    logic [63:0] plaintext        = '0;
    logic        ciphertext_valid;
    logic        ciphertext_ready = 1'b0;
    logic [63:0] ciphertext;

    // key as the block should hold it; reset clears both halves
    logic [63:0] key_low_shadow  = '0;
    logic [15:0] key_high_shadow = '0;

    // predicted ciphertext words, oldest first
    logic [63:0] pending_cipher_q[$];
    logic [63:0] cipher_want;
    int          error_count = 0;

    // set to hold both sides free of idle cycles for a long stretch
    bit          steady = 1'b0;

    lightweight_block_encrypt_80_unit #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .plaintext_valid  (plaintext_valid),
        .plaintext_ready  (plaintext_ready),
        .plaintext        (plaintext),
        .ciphertext_valid (ciphertext_valid),
        .ciphertext_ready (ciphertext_ready),
        .ciphertext       (ciphertext)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Cipher model
    // ------------------------------------------------------------------

    function automatic logic [3:0] subst_nibble(input logic [3:0] x);
        case (x)
            4'h0: subst_nibble = 4'hc;
            4'h1: subst_nibble = 4'h5;
            4'h2: subst_nibble = 4'h6;
            4'h3: subst_nibble = 4'hb;
            4'h4: subst_nibble = 4'h9;
            4'h5: subst_nibble = 4'h0;
            4'h6: subst_nibble = 4'ha;
            4'h7: subst_nibble = 4'hd;
            4'h8: subst_nibble = 4'h3;
            4'h9: subst_nibble = 4'he;
            4'ha: subst_nibble = 4'hf;
            4'hb: subst_nibble = 4'h8;
            4'hc: subst_nibble = 4'h4;
            4'hd: subst_nibble = 4'h7;
            4'he: subst_nibble = 4'h1;
            default: subst_nibble = 4'h2;
        endcase
    endfunction

    // One full round: key mix, nibble substitution, bit shuffle.
    function automatic logic [63:0] cipher_round(input logic [63:0] blk,
                                                 input logic [63:0] rkey);
        logic [63:0] mixed;
        logic [63:0] subbed;
        logic [63:0] shuffled;
        mixed = blk ^ rkey;
        for (int n = 0; n < 16; n++)
        begin
            subbed[4*n +: 4] = subst_nibble(mixed[4*n +: 4]);
        end
        shuffled[63] = subbed[63];
        for (int i = 0; i < 63; i++)
        begin
            shuffled[(i * 16) % 63] = subbed[i];
        end
        return shuffled;
    endfunction

    // Run the whole schedule from the master key and return the ciphertext.
    function automatic logic [63:0] encrypt_block(input logic [63:0] pt,
                                                  input logic [63:0] k_low,
                                                  input logic [15:0] k_high);
        logic [79:0] kreg;
        logic [63:0] blk;
        logic [4:0]  rnd;
        kreg = {k_high, k_low};
        blk  = pt;
        for (int r = 1; r <= ROUNDS; r++)
        begin
            rnd  = r[4:0];
            blk  = cipher_round(blk, kreg[79:16]);
            kreg = {kreg[18:0], kreg[79:19]};
            kreg[79:76] = subst_nibble(kreg[79:76]);
            kreg[19:15] = kreg[19:15] ^ rnd;
        end
        return blk ^ kreg[79:16];
    endfunction

    // ------------------------------------------------------------------
    // Output side: random backpressure and in-order compare
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        ciphertext_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && ciphertext_valid && ciphertext_ready)
        begin
            if (pending_cipher_q.size() == 0)
            begin
                $display("%0t ns: ciphertext word with none expected, actual %h",
                         $time, ciphertext);
                error_count++;
            end
            else
            begin
                cipher_want = pending_cipher_q.pop_front();
                if (ciphertext !== cipher_want)
                begin
                    $display("%0t ns: ciphertext mismatch, expected %h actual %h",
                             $time, cipher_want, ciphertext);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Write both key halves; call only while the chain is empty. The high
    // register keeps only the low 16 bits of whatever data is written.
    task automatic load_key(input logic [63:0] low_word, input logic [63:0] high_word);
        cfg_we    <= 1'b1;
        cfg_index <= prs80_pkg::REG_KEY_LOW;
        cfg_data  <= low_word;
        @(posedge clk);
        cfg_index <= prs80_pkg::REG_KEY_HIGH;
        cfg_data  <= high_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_low_shadow  = low_word;
        key_high_shadow = high_word[15:0];
    endtask

    // Present one plaintext word and hold it until the block takes it.
    task automatic send_block(input logic [63:0] pt);
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            plaintext_valid <= 1'b0;
            @(posedge clk);
        end
        plaintext_valid <= 1'b1;
        plaintext       <= pt;
        do
            @(posedge clk);
        while (!plaintext_ready);
        pending_cipher_q.push_back(encrypt_block(pt, key_low_shadow, key_high_shadow));
    endtask

    // Drop valid and hold until every predicted word has come out.
    task automatic drain_chain();
        plaintext_valid <= 1'b0;
        while (pending_cipher_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Plaintext mix: mostly dense random, with sparse, near-full and
    // repeated-nibble words so single bits and nibble values get exercised.
    function automatic logic [63:0] random_plaintext();
        logic [63:0] w;
        case ($urandom_range(9))
            0: w = 64'h1 << $urandom_range(63);
            1: w = ~(64'h1 << $urandom_range(63));
            2: w = {16{4'($urandom_range(15))}};
            3: w = $urandom_range(1) ? '0 : '1;
            default: w = random_word();
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Check the model against the published answers for all-zero and
    // all-one keys and blocks, and run the same blocks through the chain.
    // The first two go out under the key left by reset.
    task automatic test_known_answers();
        logic [63:0] vec_pt [4];
        logic [63:0] vec_ct [4];
        vec_pt = '{64'h0, '1, 64'h0, '1};
        vec_ct = '{64'h5579C1387B228445, 64'hA112FFC72F68417B,
                   64'hE72C46C0F5945049, 64'h3333DCD3213210D2};
        for (int v = 0; v < 4; v++)
        begin
            if (v == 2)
            begin
                drain_chain();
                load_key('1, '1);
            end
            if (encrypt_block(vec_pt[v], key_low_shadow, key_high_shadow) !== vec_ct[v])
            begin
                $display("%0t ns: model answer mismatch, expected %h actual %h", $time,
                         vec_ct[v], encrypt_block(vec_pt[v], key_low_shadow, key_high_shadow));
                error_count++;
            end
            send_block(vec_pt[v]);
        end
        drain_chain();
    endtask

    // Corner blocks and keys: single end bits, alternating bits, counting
    // nibbles; key with garbage above bit 15 of the high write; keys with
    // only one half populated.
    task automatic test_edge_patterns();
        load_key(64'h0000_0000_0000_0001, 64'hDEAD_BEEF_CAFE_8001);
        send_block(64'h0000_0000_0000_0001);
        send_block(64'h8000_0000_0000_0000);
        send_block(64'h5555_5555_5555_5555);
        send_block(64'hAAAA_AAAA_AAAA_AAAA);
        send_block(64'h0123_4567_89AB_CDEF);
        send_block(64'hFEDC_BA98_7654_3210);
        send_block(64'h8000_0000_0000_0001);
        drain_chain();
        load_key(64'h0, 64'h0000_0000_0000_FFFF);
        send_block(64'h0);
        send_block(64'h0123_4567_89AB_CDEF);
        drain_chain();
        load_key('1, 64'h0);
        send_block('1);
        send_block(64'hFEDC_BA98_7654_3210);
        drain_chain();
    endtask

    // Random traffic in phases, each under a fresh key. One phase runs with
    // no idle cycles on either side; the first phase stops halfway and lets
    // the chain empty before resuming.
    task automatic test_random_traffic();
        int phases;
        phases = RANDOM_BLOCKS / PHASE_BLOCKS;
        for (int p = 0; p < phases; p++)
        begin
            case (p % 7)
                1: load_key('0, {random_word()} & 64'hFFFF_FFFF_FFFF_0000);
                4: load_key('1, {random_word()} | 64'h0000_0000_0000_FFFF);
                default: load_key(random_word(), random_word());
            endcase
            steady = (p == 3);
            for (int b = 0; b < PHASE_BLOCKS; b++)
            begin
                if ((p == 0 && b == PHASE_BLOCKS / 2) || $urandom_range(199) == 0)
                    drain_chain();
                send_block(random_plaintext());
            end
            drain_chain();
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_known_answers();
        test_edge_patterns();
        test_random_traffic();

        // let the chain run dry to catch stray words
        drain_chain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_cipher_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
